// ===== design/assert_macros.svh =====
// assertion helpers included by keyed_table_engine.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge, also while reset is asserted
`define KTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// checked only outside reset
`define KTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ===== design/kte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kte_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned KeyW     = 16;
  localparam int unsigned ValW     = 32;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_DUP       = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/kte_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kte_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/keyed_table_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// keyed table engine: up to 16 unique keys, each with a 32-bit value, kept
// compacted in insertion order in one single-port-write, one-read ram.
// a request beat is taken when start is high and busy is low; it carries
// operation_i (add, delete, update, get), key_i, new_key_i and value_i.
// exactly one result beat follows, shown for one cycle with done_o high:
// status_o, found_key_o, found_value_o and entry_total_o.
// an add to a full table answers without a scan. otherwise the stored
// entries are read one per cycle through the ram read port; a delete then
// moves each later entry down, one per cycle, before the result.
// busy stays high from the accepted beat until the result cycle ends.
// capacity_i is written with capacity_we_i; the user must do so only while
// the block is idle, the block itself does not enforce it. limits above 16
// saturate at 16. reset empties the table and sets capacity to 16; ram
// contents are not cleared and are never read before written.
// the receiver cannot stall: the result is gone after its one cycle.
module keyed_table_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [kte_pkg::OpW-1:0]        operation_i,
  input  wire logic [kte_pkg::KeyW-1:0]       key_i,
  input  wire logic [kte_pkg::KeyW-1:0]       new_key_i,
  input  wire logic [kte_pkg::ValW-1:0]       value_i,
  input  wire logic                           capacity_we_i,
  input  wire logic [kte_pkg::CntW-1:0]       capacity_i,
  output logic                                done_o,
  output logic      [kte_pkg::StatusW-1:0]    status_o,
  output logic      [kte_pkg::KeyW-1:0]       found_key_o,
  output logic      [kte_pkg::ValW-1:0]       found_value_o,
  output logic      [kte_pkg::CntW-1:0]       entry_total_o
);
  import kte_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic            done_q, done_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cap_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            found_q, found_d;
  logic            dup_q, dup_d;

  op_e             op_q, op_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [KeyW-1:0] nkey_q, nkey_d;
  logic [ValW-1:0] val_q, val_d;
  status_e         res_status_q, res_status_d;
  logic [KeyW-1:0] res_key_q, res_key_d;
  logic [ValW-1:0] res_val_q, res_val_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;

  logic [CntW-1:0] limit;
  logic [CntW-1:0] idx_next;
  logic [CntW-1:0] pos_next;

  kte_ram #(
    .Width($bits(entry_t)),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign limit    = (cap_q < CntW'(Depth)) ? cap_q : CntW'(Depth);
  assign idx_next = CntW'(idx_q) + CntW'(1);
  assign pos_next = CntW'(pos_q) + CntW'(1);

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    count_d      = count_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    found_d      = found_q;
    dup_d        = dup_q;
    op_d         = op_q;
    key_d        = key_q;
    nkey_d       = nkey_q;
    val_d        = val_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = '{key: nkey_q, value: val_q};
    mem_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start && !done_q) begin
          op_d         = op_e'(operation_i);
          key_d        = key_i;
          nkey_d       = new_key_i;
          val_d        = value_i;
          found_d      = 1'b0;
          dup_d        = 1'b0;
          idx_d        = '0;
          res_key_d    = '0;
          res_val_d    = '0;
          res_status_d = STAT_OK;
          if (op_e'(operation_i) == OP_ADD && count_q >= limit) begin
            res_status_d = STAT_FULL;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else if (count_q == '0) begin
            state_d = S_EVAL;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (mem_rdata.key == key_q) begin
          if (!found_q) begin
            found_d   = 1'b1;
            pos_d     = idx_q;
            res_val_d = mem_rdata.value;
          end
        end else if (mem_rdata.key == nkey_q) begin
          dup_d = 1'b1;
        end
        if (idx_next == count_q) begin
          state_d = S_EVAL;
        end else begin
          idx_d     = idx_next[IdxW-1:0];
          mem_raddr = idx_next[IdxW-1:0];
        end
      end

      S_EVAL: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        unique case (op_q)
          OP_ADD: begin
            res_val_d = '0;
            if (found_q) begin
              res_status_d = STAT_DUP;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[IdxW-1:0];
              mem_wdata = '{key: key_q, value: val_q};
              count_d   = count_q + CntW'(1);
            end
          end
          OP_DELETE: begin
            res_val_d = '0;
            if (!found_q) begin
              res_status_d = STAT_NOT_FOUND;
            end else if (pos_next == count_q) begin
              count_d = count_q - CntW'(1);
            end else begin
              done_d    = 1'b0;
              state_d   = S_SHIFT;
              idx_d     = pos_next[IdxW-1:0];
              mem_raddr = pos_next[IdxW-1:0];
            end
          end
          OP_UPDATE: begin
            res_val_d = '0;
            if (dup_q) begin
              res_status_d = STAT_DUP;
            end else if (!found_q) begin
              res_status_d = STAT_NOT_FOUND;
            end else begin
              mem_we = 1'b1;
            end
          end
          OP_GET: begin
            if (!found_q) begin
              res_status_d = STAT_NOT_FOUND;
              res_val_d    = '0;
            end else begin
              res_key_d = key_q;
            end
          end
          default: begin
            res_val_d = '0;
          end
        endcase
      end

      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q - IdxW'(1);
        mem_wdata = mem_rdata;
        if (idx_next == count_q) begin
          count_d = count_q - CntW'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d     = idx_next[IdxW-1:0];
          mem_raddr = idx_next[IdxW-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
      cap_q   <= CntW'(Depth);
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      count_q <= count_d;
      if (capacity_we_i) begin
        cap_q <= capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    found_q      <= found_d;
    dup_q        <= dup_d;
    op_q         <= op_d;
    key_q        <= key_d;
    nkey_q       <= nkey_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
  end

  // done cycle counts as busy so no beat is taken before the result leaves
  assign busy          = (state_q != S_IDLE) || done_q;
  assign done_o        = done_q;
  assign status_o      = res_status_q;
  assign found_key_o   = res_key_q;
  assign found_value_o = res_val_q;
  assign entry_total_o = count_q;

  `KTE_ASSERT_ALWAYS(a_count_bound, (count_q <= CntW'(Depth)), "entry count above depth")
  `KTE_ASSERT(a_count_step, ((count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) || (count_q + CntW'(1) == $past(count_q))), "entry count jumped")
  `KTE_ASSERT(a_accept_busy, ((start && !busy) |=> busy), "no busy after accepted beat")
  `KTE_ASSERT(a_done_idle, (done_o |-> (state_q == S_IDLE)), "result shown while work pending")
  `KTE_ASSERT(a_shift_found, ((state_q == S_SHIFT) |-> (found_q && op_q == OP_DELETE)), "shift without a found delete")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kte_pkg::*;

  typedef struct packed {
    status_e         st;
    logic [KeyW-1:0] fkey;
    logic [ValW-1:0] fval;
    logic [CntW-1:0] total;
  } result_t;

  typedef struct packed {
    logic            is_cfg;
    logic [CntW-1:0] cap;
    op_e             op;
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] nkey;
    logic [ValW-1:0] val;
    logic            typed;
    result_t         exp;
  } step_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 180;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [OpW-1:0]  operation_i;
  logic [KeyW-1:0] key_i;
  logic [KeyW-1:0] new_key_i;
  logic [ValW-1:0] value_i;
  logic            capacity_we_i;
  logic [CntW-1:0] capacity_i;
  logic            done_o;
  logic [StatusW-1:0] status_o;
  logic [KeyW-1:0] found_key_o;
  logic [ValW-1:0] found_value_o;
  logic [CntW-1:0] entry_total_o;

  keyed_table_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .new_key_i     (new_key_i),
    .value_i       (value_i),
    .capacity_we_i (capacity_we_i),
    .capacity_i    (capacity_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_key_o   (found_key_o),
    .found_value_o (found_value_o),
    .entry_total_o (entry_total_o)
  );

  // shadow copy of the table
  logic [KeyW-1:0] tbl_key [Depth];
  logic [ValW-1:0] tbl_val [Depth];
  int unsigned     tbl_count;
  logic [CntW-1:0] tbl_cap;

  result_t         pending_results [$];
  logic [KeyW-1:0] key_pool [24];
  int unsigned     mismatch_count;
  int unsigned     cycle_count;

  step_t plan [27] = '{
    '{1'b0, 5'd0, OP_GET,    16'h0000, 16'h0000, 32'h0, 1'b1,
      '{STAT_NOT_FOUND, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_DELETE, 16'hFFFF, 16'h0000, 32'h0, 1'b1,
      '{STAT_NOT_FOUND, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_UPDATE, 16'h0000, 16'h0005, 32'h0, 1'b1,
      '{STAT_NOT_FOUND, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_ADD,    16'h0000, 16'h0000, 32'h0, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd1}},
    '{1'b0, 5'd0, OP_ADD,    16'hFFFF, 16'h0000, 32'hFFFFFFFF, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd2}},
    '{1'b0, 5'd0, OP_ADD,    16'h0000, 16'h0000, 32'h1, 1'b1,
      '{STAT_DUP, 16'h0, 32'h0, 5'd2}},
    '{1'b0, 5'd0, OP_GET,    16'hFFFF, 16'h0000, 32'h0, 1'b1,
      '{STAT_OK, 16'hFFFF, 32'hFFFFFFFF, 5'd2}},
    '{1'b0, 5'd0, OP_GET,    16'h0000, 16'h0000, 32'h0, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd2}},
    '{1'b0, 5'd0, OP_ADD,    16'h1234, 16'h0000, 32'hA5A5A5A5, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd3}},
    '{1'b0, 5'd0, OP_UPDATE, 16'h0000, 16'hFFFF, 32'h0, 1'b1,
      '{STAT_DUP, 16'h0, 32'h0, 5'd3}},
    '{1'b0, 5'd0, OP_UPDATE, 16'h0000, 16'h0000, 32'h5A5A5A5A, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd3}},
    '{1'b0, 5'd0, OP_UPDATE, 16'h7777, 16'h8888, 32'h0, 1'b1,
      '{STAT_NOT_FOUND, 16'h0, 32'h0, 5'd3}},
    '{1'b0, 5'd0, OP_UPDATE, 16'h7777, 16'h1234, 32'h0, 1'b1,
      '{STAT_DUP, 16'h0, 32'h0, 5'd3}},
    '{1'b0, 5'd0, OP_UPDATE, 16'h1234, 16'h4321, 32'h1, 1'b0,
      '{STAT_OK, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_GET,    16'h4321, 16'h0000, 32'h0, 1'b0,
      '{STAT_OK, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_DELETE, 16'h0000, 16'h0000, 32'h0, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd2}},
    '{1'b0, 5'd0, OP_GET,    16'hFFFF, 16'h0000, 32'h0, 1'b0,
      '{STAT_OK, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_DELETE, 16'h4321, 16'h0000, 32'h0, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd1}},
    '{1'b0, 5'd0, OP_DELETE, 16'h4321, 16'h0000, 32'h0, 1'b1,
      '{STAT_NOT_FOUND, 16'h0, 32'h0, 5'd1}},
    '{1'b1, 5'd2, OP_GET,    16'h0000, 16'h0000, 32'h0, 1'b0,
      '{STAT_OK, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_ADD,    16'h0001, 16'h0000, 32'h80000000, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd2}},
    '{1'b0, 5'd0, OP_ADD,    16'h0002, 16'h0000, 32'h0, 1'b1,
      '{STAT_FULL, 16'h0, 32'h0, 5'd2}},
    '{1'b0, 5'd0, OP_ADD,    16'hFFFF, 16'h0000, 32'h0, 1'b1,
      '{STAT_FULL, 16'h0, 32'h0, 5'd2}},
    '{1'b1, 5'd0, OP_GET,    16'h0000, 16'h0000, 32'h0, 1'b0,
      '{STAT_OK, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_GET,    16'h0001, 16'h0000, 32'h0, 1'b0,
      '{STAT_OK, 16'h0, 32'h0, 5'd0}},
    '{1'b0, 5'd0, OP_ADD,    16'h0003, 16'h0000, 32'h0, 1'b1,
      '{STAT_FULL, 16'h0, 32'h0, 5'd2}},
    '{1'b0, 5'd0, OP_DELETE, 16'h0001, 16'h0000, 32'h0, 1'b1,
      '{STAT_OK, 16'h0, 32'h0, 5'd1}}
  };

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic result_t table_apply(op_e op, logic [KeyW-1:0] k,
                                          logic [KeyW-1:0] nk, logic [ValW-1:0] v);
    result_t     r;
    int          slot;
    int unsigned lim;
    bit          clash;
    r = '{STAT_OK, '0, '0, '0};
    lim = (tbl_cap < Depth) ? tbl_cap : Depth;
    slot = -1;
    clash = 1'b0;
    for (int i = 0; i < int'(tbl_count); i++) begin
      if (slot < 0 && tbl_key[i] == k) slot = i;
      if (tbl_key[i] != k && tbl_key[i] == nk) clash = 1'b1;
    end
    case (op)
      OP_ADD: begin
        if (tbl_count >= lim) r.st = STAT_FULL;
        else if (slot >= 0) r.st = STAT_DUP;
        else begin
          tbl_key[tbl_count] = k;
          tbl_val[tbl_count] = v;
          tbl_count++;
        end
      end
      OP_DELETE: begin
        if (slot < 0) r.st = STAT_NOT_FOUND;
        else begin
          for (int i = slot; i + 1 < int'(tbl_count); i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_val[i] = tbl_val[i+1];
          end
          tbl_count--;
        end
      end
      OP_UPDATE: begin
        if (clash) r.st = STAT_DUP;
        else if (slot < 0) r.st = STAT_NOT_FOUND;
        else begin
          tbl_key[slot] = nk;
          tbl_val[slot] = v;
        end
      end
      default: begin
        if (slot < 0) r.st = STAT_NOT_FOUND;
        else begin
          r.fkey = tbl_key[slot];
          r.fval = tbl_val[slot];
        end
      end
    endcase
    r.total = CntW'(tbl_count);
    return r;
  endfunction

  task automatic issue(input op_e op, input logic [KeyW-1:0] k, input logic [KeyW-1:0] nk,
                       input logic [ValW-1:0] v, input bit typed, input result_t given);
    result_t calc;
    start       <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    new_key_i   <= nk;
    value_i     <= v;
    do @(posedge clk_i); while (busy);
    calc = table_apply(op, k, nk, v);
    pending_results.push_back(typed ? given : calc);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CntW-1:0] v);
    settle();
    capacity_we_i <= 1'b1;
    capacity_i    <= v;
    @(posedge clk_i);
    capacity_we_i <= 1'b0;
    tbl_cap = v;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: status %0d key %h value %h total %0d",
                   status_o, found_key_o, found_value_o, entry_total_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.st || found_key_o !== want.fkey ||
            found_value_o !== want.fval || entry_total_o !== want.total) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: status %0d/%0d key %h/%h value %h/%h total %0d/%0d",
                     want.st, status_o, want.fkey, found_key_o,
                     want.fval, found_value_o, want.total, entry_total_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    step_t           s;
    logic [31:0]     r32;
    logic [CntW-1:0] cap;
    logic [KeyW-1:0] k;
    logic [KeyW-1:0] nk;
    op_e             op;
    int unsigned     pick;
    int unsigned     add_w;
    int unsigned     del_w;
    int unsigned     idle_pct;

    rst_ni        = 1'b0;
    start         = 1'b0;
    operation_i   = '0;
    key_i         = '0;
    new_key_i     = '0;
    value_i       = '0;
    capacity_we_i = 1'b0;
    capacity_i    = '0;
    tbl_count     = 0;
    tbl_cap       = CntW'(16);
    mismatch_count = 0;
    cycle_count   = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 24; i++) begin
      r32 = $urandom;
      key_pool[i] = r32[KeyW-1:0];
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      s = plan[i];
      if (s.is_cfg) write_capacity(s.cap);
      else issue(s.op, s.key, s.nkey, s.val, s.typed, s.exp);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cap = 5'd16;
        1: cap = 5'd5;
        2: cap = 5'd31;
        3: cap = 5'd0;
        4: cap = 5'd1;
        5: cap = 5'd17;
        6: cap = CntW'($urandom_range(0, 31));
        default: cap = 5'd16;
      endcase
      write_capacity(cap);
      add_w    = (ph % 2 == 0) ? 50 : 20;
      del_w    = (ph % 2 == 0) ? 15 : 40;
      idle_pct = (ph == 2 || ph == 7) ? 0 : 35;
      for (int n = 0; n < int'(PhaseItems); n++) begin
        pick = $urandom_range(0, 99);
        if (pick < add_w) op = OP_ADD;
        else if (pick < add_w + del_w) op = OP_DELETE;
        else if (pick < add_w + del_w + 20) op = OP_UPDATE;
        else op = OP_GET;

        r32 = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45 && tbl_count > 0) k = tbl_key[$urandom_range(0, tbl_count - 1)];
        else if (pick < 85) k = key_pool[$urandom_range(0, 23)];
        else k = r32[KeyW-1:0];

        r32 = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40 && tbl_count > 0) nk = tbl_key[$urandom_range(0, tbl_count - 1)];
        else if (pick < 60) nk = k;
        else if (pick < 85) nk = key_pool[$urandom_range(0, 23)];
        else nk = r32[KeyW-1:0];

        if ($urandom_range(0, 249) == 0) settle();
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk_i);
        end
        r32 = $urandom;
        issue(op, k, nk, r32, 1'b0, '0);
      end
    end

    settle();
    repeat (40) @(posedge clk_i);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
